// ===== rtl/ppg_baseline_removal_assert.svh =====
// assertion macros used by the checker file
`ifndef PPG_BASELINE_REMOVAL_ASSERT_SVH
`define PPG_BASELINE_REMOVAL_ASSERT_SVH

// same-cycle implication, masked while in reset
`define PPGBR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ppgbr assertion failed");

// next-cycle implication, masked while in reset
`define PPGBR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ppgbr assertion failed");

// next-cycle implication, checked through reset as well
`define PPGBR_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ppgbr assertion failed");

`endif

// ===== rtl/ppgbr_pkg.sv =====
package ppgbr_pkg;

  // default geometry
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF   = 16;

  // fixed field widths
  localparam int ALPHA_W    = 16;
  localparam int WARM_W     = 8;
  localparam int PLOT_W     = 28;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // wrist residual gain of 8 as a shift
  localparam int WRIST_SHIFT = 3;
  localparam int CENTRE      = 2048;

  typedef logic signed [PLOT_W-1:0] plot_t;

  localparam plot_t PLOT_MAX  = 28'sh7FFFFFF;
  localparam plot_t PLOT_MIN  = -28'sh8000000;
  localparam plot_t LAST_RST  = 28'sd2048;
  localparam plot_t MIN_RST   = 28'sd10000;
  localparam plot_t MAX_RST   = 28'sd0;

  // register reset values
  localparam logic [ALPHA_W-1:0] ALPHA_WRIST_RST  = 16'd328;
  localparam logic [ALPHA_W-1:0] ALPHA_FINGER_RST = 16'd655;
  localparam logic [ALPHA_W-1:0] ALPHA_WARMUP_RST = 16'd6554;
  localparam logic [WARM_W-1:0]  WARMUP_LEN_RST   = 8'd50;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_MODE   = 3'd0,
    REG_ALPHA_WRIST   = 3'd1,
    REG_ALPHA_FINGER  = 3'd2,
    REG_ALPHA_WARMUP  = 3'd3,
    REG_WARMUP_LENGTH = 3'd4
  } cfg_reg_e;

  // source mode codes
  localparam logic MODE_WRIST  = 1'b0;
  localparam logic MODE_FINGER = 1'b1;

  typedef struct packed {
    logic               source_mode;
    logic [ALPHA_W-1:0] alpha_wrist;
    logic [ALPHA_W-1:0] alpha_finger;
    logic [ALPHA_W-1:0] alpha_warmup;
    logic [WARM_W-1:0]  warmup_length;
  } cfg_t;

endpackage

// ===== rtl/ppgbr_channels.sv =====
// sample channel
interface ppgbr_in_if #(
  parameter int SAMPLE_BITS = ppgbr_pkg::SAMPLE_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// result channel
interface ppgbr_out_if ();
  logic                  valid;
  logic                  ready;
  ppgbr_pkg::plot_t      plot_value;
  logic                  held;
  ppgbr_pkg::plot_t      min_seen;
  ppgbr_pkg::plot_t      max_seen;

  modport source (output valid, output plot_value, output held, output min_seen,
                  output max_seen, input ready);
  modport sink (input valid, input plot_value, input held, input min_seen,
                input max_seen, output ready);
endinterface

// register write channel
interface ppgbr_cfg_if ();
  logic                                 valid;
  logic                                 ready;
  logic [ppgbr_pkg::CFG_IDX_W-1:0]      index;
  logic [ppgbr_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ppgbr_cfg_regs.sv =====
module ppgbr_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  ppgbr_cfg_if.sink       cfg_ch,
  output ppgbr_pkg::cfg_t cfg
);
  import ppgbr_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  // writes are always taken
  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  // register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_SOURCE_MODE:   cfg_nxt.source_mode   = cfg_ch.data[0];
        REG_ALPHA_WRIST:   cfg_nxt.alpha_wrist   = cfg_ch.data[ALPHA_W-1:0];
        REG_ALPHA_FINGER:  cfg_nxt.alpha_finger  = cfg_ch.data[ALPHA_W-1:0];
        REG_ALPHA_WARMUP:  cfg_nxt.alpha_warmup  = cfg_ch.data[ALPHA_W-1:0];
        REG_WARMUP_LENGTH: cfg_nxt.warmup_length = cfg_ch.data[WARM_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_mode   <= MODE_WRIST;
      cfg_r.alpha_wrist   <= ALPHA_WRIST_RST;
      cfg_r.alpha_finger  <= ALPHA_FINGER_RST;
      cfg_r.alpha_warmup  <= ALPHA_WARMUP_RST;
      cfg_r.warmup_length <= WARMUP_LEN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/ppgbr_core.sv =====
module ppgbr_core #(
  parameter int SAMPLE_BITS = ppgbr_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = ppgbr_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ppgbr_pkg::cfg_t cfg,
  ppgbr_in_if.sink        in_ch,
  ppgbr_out_if.source     out_ch
);
  import ppgbr_pkg::*;

  localparam int BW  = SAMPLE_BITS + FRAC_BITS;
  localparam int PW  = BW + ALPHA_W;
  localparam int GW  = BW + WRIST_SHIFT;
  localparam int IPW = SAMPLE_BITS + WRIST_SHIFT;
  localparam int VW  = IPW + 2;
  localparam int EW  = (VW > PLOT_W) ? VW : PLOT_W;

  // input register
  logic                   s1_valid_r, s1_valid_nxt;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic                   adv;

  // filter state
  logic [BW-1:0]     baseline_r, baseline_nxt;
  logic              seeded_r, seeded_nxt;
  logic [WARM_W-1:0] warm_cnt_r, warm_cnt_nxt;
  plot_t             last_pt_r, last_pt_nxt;
  plot_t             min_r, min_nxt;
  plot_t             max_r, max_nxt;

  // result register
  logic  out_valid_r, out_valid_nxt;
  plot_t out_plot_r, out_plot_nxt;
  logic  out_held_r, out_held_nxt;

  // datapath
  logic [BW-1:0]        xs, base_eff, mag, step, upd;
  logic                 neg, is_wrist, is_zero, warm, produce, track;
  logic [ALPHA_W-1:0]   alpha;
  logic [PW-1:0]        prod;
  logic [PW:0]          rnd_sum;
  logic [GW-1:0]        gained;
  logic [IPW-1:0]       ip;
  logic signed [VW-1:0] ipx, v;
  logic signed [EW-1:0] ve;
  plot_t                plot_sat;

  // an item moves on when the result slot is free or being drained
  assign adv          = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || adv;
  assign s1_valid_nxt = (in_ch.valid && in_ch.ready) || (s1_valid_r && !adv);

  // residual against the baseline, seeding folds into a zero residual
  assign xs       = {s1_sample_r, {FRAC_BITS{1'b0}}};
  assign base_eff = seeded_r ? baseline_r : xs;
  assign neg      = xs < base_eff;
  assign mag      = neg ? (base_eff - xs) : (xs - base_eff);

  assign is_wrist = (cfg.source_mode == MODE_WRIST);
  assign is_zero  = (s1_sample_r == '0);
  assign warm     = (warm_cnt_r < cfg.warmup_length);

  // baseline step, floor toward the sample on the way up, ceil on the way down
  assign alpha   = is_wrist ? cfg.alpha_wrist : (warm ? cfg.alpha_warmup : cfg.alpha_finger);
  assign prod    = PW'(mag) * PW'(alpha);
  assign rnd_sum = neg ? ({1'b0, prod} + (PW+1)'({ALPHA_W{1'b1}})) : {1'b0, prod};
  assign step    = rnd_sum[PW-1:ALPHA_W];
  assign upd     = neg ? (base_eff - step) : (base_eff + step);

  // plot value: gain, drop fraction, recentre, saturate
  assign gained = is_wrist ? (GW'(mag) << WRIST_SHIFT) : GW'(mag);
  assign ip     = gained[GW-1:FRAC_BITS];
  assign ipx    = VW'(ip);
  assign v      = (neg ? -ipx : ipx) + VW'(CENTRE);
  assign ve     = EW'(v);

  always_comb begin
    if (ve > EW'(PLOT_MAX)) begin
      plot_sat = PLOT_MAX;
    end else if (ve < EW'(PLOT_MIN)) begin
      plot_sat = PLOT_MIN;
    end else begin
      plot_sat = ve[PLOT_W-1:0];
    end
  end

  // mode rules and state update
  always_comb begin
    baseline_nxt  = baseline_r;
    seeded_nxt    = seeded_r;
    warm_cnt_nxt  = warm_cnt_r;
    last_pt_nxt   = last_pt_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    produce       = 1'b0;
    track         = 1'b0;
    out_plot_nxt  = out_plot_r;
    out_held_nxt  = out_held_r;
    if (adv) begin
      out_plot_nxt = plot_sat;
      out_held_nxt = 1'b0;
      if (is_wrist) begin
        baseline_nxt = upd;
        seeded_nxt   = 1'b1;
        produce      = 1'b1;
        track        = 1'b1;
      end else if (is_zero) begin
        if (warm) begin
          warm_cnt_nxt = warm_cnt_r + 1'b1;
        end else begin
          produce      = 1'b1;
          out_plot_nxt = last_pt_r;
          out_held_nxt = 1'b1;
        end
      end else if (warm) begin
        warm_cnt_nxt = warm_cnt_r + 1'b1;
        baseline_nxt = upd;
        seeded_nxt   = 1'b1;
      end else begin
        baseline_nxt = upd;
        seeded_nxt   = 1'b1;
        produce      = 1'b1;
        track        = 1'b1;
        last_pt_nxt  = plot_sat;
      end
    end
    if (track) begin
      if (plot_sat < min_r) begin
        min_nxt = plot_sat;
      end
      if (plot_sat > max_r) begin
        max_nxt = plot_sat;
      end
    end
  end

  assign out_valid_nxt = adv ? produce : (out_valid_r && !out_ch.ready);

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      baseline_r  <= '0;
      seeded_r    <= 1'b0;
      warm_cnt_r  <= '0;
      last_pt_r   <= LAST_RST;
      min_r       <= MIN_RST;
      max_r       <= MAX_RST;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      baseline_r  <= baseline_nxt;
      seeded_r    <= seeded_nxt;
      warm_cnt_r  <= warm_cnt_nxt;
      last_pt_r   <= last_pt_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_sample_r <= in_ch.sample;
    end
    out_plot_r <= out_plot_nxt;
    out_held_r <= out_held_nxt;
  end

  // extrema only move when a result is loaded, so they read straight out
  assign out_ch.valid      = out_valid_r;
  assign out_ch.plot_value = out_plot_r;
  assign out_ch.held       = out_held_r;
  assign out_ch.min_seen   = min_r;
  assign out_ch.max_seen   = max_r;

endmodule

// ===== rtl/ppg_baseline_removal.sv =====
// PPG baseline removal: takes one raw sample per transfer and returns the
// sample minus an exponential moving-average baseline, centred on 2048 and
// saturated to 28 bits signed, with the running minimum and maximum. Wrist
// mode (source_mode 0) plots every sample at a residual gain of 8; finger
// mode skips warmup_length samples first and repeats the last point (held
// set) for a zero sample. Warm-up samples produce no result. A sample passes
// through the input register, then through the residual, the 40x16 baseline
// multiply and saturation into the result register. The baseline loop closes
// in that single stage, so a new sample is taken every cycle while the result
// side keeps up. The user must write registers over the cfg channel only while
// no sample is in flight; the block itself does not enforce this.
module ppg_baseline_removal #(
  parameter int SAMPLE_BITS = ppgbr_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = ppgbr_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ppgbr_in_if.sink    in_ch,
  ppgbr_out_if.source out_ch,
  ppgbr_cfg_if.sink   cfg_ch
);
  import ppgbr_pkg::*;

  cfg_t cfg;

  // register file
  ppgbr_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // filter pipeline
  ppgbr_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

// ===== rtl/ppgbr_checker.sv =====
`include "ppg_baseline_removal_assert.svh"

module ppgbr_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input ppgbr_pkg::plot_t plot_value,
  input logic             held,
  input ppgbr_pkg::plot_t min_seen,
  input ppgbr_pkg::plot_t max_seen
);
  import ppgbr_pkg::*;

  // no result comes out of reset
  `PPGBR_ASSERT_NXT_ALWAYS(a_no_result_after_rst, clk, !rst_n, !out_valid)

  // a stalled result keeps its value
  `PPGBR_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(plot_value) && $stable(held))

  // a fresh point lies inside the tracked range
  `PPGBR_ASSERT_IMP(a_in_range, clk, rst_n, out_valid && !held, (plot_value >= min_seen) && (plot_value <= max_seen))

  // once a point is tracked the range is never inverted
  `PPGBR_ASSERT_IMP(a_range_order, clk, rst_n, out_valid && !held, min_seen <= max_seen)

endmodule

bind ppg_baseline_removal ppgbr_checker u_ppgbr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .plot_value (out_ch.plot_value),
  .held       (out_ch.held),
  .min_seen   (out_ch.min_seen),
  .max_seen   (out_ch.max_seen)
);
